FILE: sv/pnm_pkg.sv
// shared types and constants for the pnm to rgb555 decoder
package pnm_pkg;

    localparam int DimBitsDefault = 16;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    localparam logic [2:0] FMT_P1 = 3'd0;
    localparam logic [2:0] FMT_P2 = 3'd1;
    localparam logic [2:0] FMT_P3 = 3'd2;
    localparam logic [2:0] FMT_P5 = 3'd3;
    localparam logic [2:0] FMT_P6 = 3'd4;

    // classified request from the front end to the back end
    typedef struct packed {
        logic        is_sample;  // sample value to scale
        logic        is_pixel;   // finished pixel, components given
        logic        is_header;
        logic        is_error;
        logic [15:0] value;
        logic [4:0]  red;
        logic [4:0]  green;
        logic [4:0]  blue;
        logic        last;
        logic        to_pixel;   // sample completes a pixel
        logic [1:0]  comp;       // component slot of the sample
        logic        gray;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] maxval;
        logic [2:0]  format;
    } t_op;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  red;
        logic [4:0]  green;
        logic [4:0]  blue;
        logic        last_pixel;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] sample_max;
        logic [2:0]  format;
    } t_res;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

FILE: sv/pnm_if.sv
// valid / ready channel interfaces
interface pnm_in_if import pnm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_file;
    modport source (output valid, in_byte, start_file, input ready);
    modport sink (input valid, in_byte, start_file, output ready);
endinterface

interface pnm_out_if import pnm_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [4:0]  red;
    logic [4:0]  green;
    logic [4:0]  blue;
    logic        last_pixel;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] sample_max;
    logic [2:0]  format;
    modport source (output valid, kind, red, green, blue, last_pixel, image_width,
                    image_height, sample_max, format, input ready);
    modport sink (input valid, kind, red, green, blue, last_pixel, image_width,
                  image_height, sample_max, format, output ready);
endinterface

FILE: sv/pnm_stream_to_rgb555_top.sv
// top level of the pnm stream to rgb555 decoder
//
// Input channel: one file byte per request, with start_file marking the
// first byte of a new file (this resets the parser). Output channel: one
// result per request, kind pixel, header accepted or error; pixels carry
// 5-bit red, green and blue and last_pixel on the final pixel.
// A front end parses the header and lexes samples, one byte a cycle while
// the queue has room and no pixel count is pending; a four-entry queue
// decouples it from the back end, which scales each sample as v*31/maxval
// with a restoring divider, one quotient bit a cycle. The back end takes a
// new request only while idle, so it handles one request at a time. The
// header result waits for the registered pixel count multiply. Direct
// results pass through the queue and the result register; scaled ones
// also pass through the divider. Reset is synchronous and clears all
// parser state and the queue. When the receiver stalls, the result
// register holds, the queue fills and the input stops taking bytes;
// nothing is lost.
module pnm_stream_to_rgb555_top import pnm_pkg::*; #(
    parameter int DIM_BITS = DimBitsDefault
) (
    input logic i_clk,
    input logic i_rst_n,
    pnm_in_if.sink    i_in,
    pnm_out_if.source o_out
);
    logic f_valid, q_ready, b_valid, b_ready;
    t_op  f_op, b_op;
    t_res res;

    pnm_front #(.DIM_BITS(DIM_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_byte(i_in.in_byte), .i_start(i_in.start_file),
        .o_op_valid(f_valid), .o_op(f_op), .i_op_ready(q_ready)
    );

    pnm_queue #(.DEPTH(4)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(q_ready), .i_op(f_op),
        .o_valid(b_valid), .i_ready(b_ready), .o_op(b_op)
    );

    pnm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(b_valid), .o_ready(b_ready), .i_op(b_op),
        .o_valid(o_out.valid), .i_ready(o_out.ready), .o_res(res)
    );

    assign o_out.kind = res.kind;
    assign o_out.red = res.red;
    assign o_out.green = res.green;
    assign o_out.blue = res.blue;
    assign o_out.last_pixel = res.last_pixel;
    assign o_out.image_width = res.image_width;
    assign o_out.image_height = res.image_height;
    assign o_out.sample_max = res.sample_max;
    assign o_out.format = res.format;
endmodule

FILE: sv/pnm_front.sv
// front end: header parser and sample lexer, one request per byte at most
module pnm_front import pnm_pkg::*; #(
    parameter int DIM_BITS = DimBitsDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    output logic       o_op_valid,
    output t_op        o_op,
    input  logic       i_op_ready
);
    localparam int AccBits = (DIM_BITS > 16 ? DIM_BITS : 16) + 1;
    localparam logic [AccBits-1:0] DimMax = AccBits'((64'd1 << DIM_BITS) - 64'd1);
    localparam logic [AccBits-1:0] AccCap =
        (DIM_BITS > 16 ? DimMax : AccBits'(17'd65535)) + AccBits'(1);
    localparam logic [AccBits-1:0] Max16 = AccBits'(17'd65535);

    typedef enum logic [2:0] {
        PH_MAGIC, PH_TYPE, PH_HEADER, PH_DATA, PH_IDLE
    } t_phase;
    typedef enum logic [1:0] {LX_WORD, LX_WSP, LX_COMMENT} t_lex;

    t_phase r_phase, n_phase;
    t_lex   r_lx, n_lx, r_prev, n_prev;
    logic [2:0]  r_fmt, n_fmt;
    logic [1:0]  r_wc, n_wc;
    logic [AccBits-1:0] r_acc, n_acc;
    logic        r_bad, n_bad;
    logic [DIM_BITS-1:0] r_w, n_w, r_h, n_h;
    logic [15:0] r_max, n_max;
    logic [1:0]  r_comp, n_comp;
    logic [7:0]  r_hi, n_hi;
    logic        r_hp, n_hp;
    logic [31:0] r_left, n_left;
    // pixel count multiply is split off: header result waits for the registered product
    logic        r_cnt_pend, n_cnt_pend;
    logic [2*DIM_BITS-1:0] r_prod;

    logic emit;
    t_op  op;

    assign o_ready = i_op_ready && !r_cnt_pend;
    wire fire = i_valid && o_ready;

    // decimal digit accumulation with saturation
    function automatic logic [AccBits-1:0] acc_next(input logic [AccBits-1:0] a,
                                                   input logic [7:0] c);
        logic [AccBits+3:0] v;
        v = {4'd0, a} * (AccBits+4)'(10) + (AccBits+4)'(c - 8'd48);
        return (v > {4'd0, AccCap}) ? AccCap : v[AccBits-1:0];
    endfunction

    wire is_dig_c = i_byte >= 8'd48 && i_byte <= 8'd57;

    always_comb begin
        t_phase ph;
        t_lex   lx;
        t_lex   pv;
        logic [15:0] sval;
        logic        do_sample;
        logic        px;
        logic [4:0]  pv5;
        ph = r_phase; lx = r_lx; pv = r_prev;
        n_phase = r_phase; n_lx = r_lx; n_prev = r_prev; n_fmt = r_fmt; n_wc = r_wc;
        n_acc = r_acc; n_bad = r_bad; n_w = r_w; n_h = r_h; n_max = r_max;
        n_comp = r_comp; n_hi = r_hi; n_hp = r_hp; n_left = r_left;
        n_cnt_pend = 1'b0;
        emit = 1'b0;
        op = '0;
        sval = '0; do_sample = 1'b0; px = 1'b0; pv5 = '0;
        if (r_cnt_pend) begin
            // header accepted, pixel count now known
            n_left = (r_prod[2*DIM_BITS-1 -: 0+1] == 1'b1 && 2*DIM_BITS > 32)
                ? 32'hFFFF_FFFF : 32'(r_prod);
            if (2*DIM_BITS > 32 && (r_prod >> 32) != '0) n_left = 32'hFFFF_FFFF;
            n_phase = (r_prod != '0) ? PH_DATA : PH_IDLE;
            emit = 1'b1;
            op.is_header = 1'b1;
        end else if (fire) begin
            if (i_start) begin
                ph = PH_MAGIC; lx = LX_WSP; pv = LX_WORD;
                n_fmt = '0; n_wc = '0; n_acc = '0; n_bad = 1'b0; n_w = '0; n_h = '0;
                n_max = '0; n_comp = '0; n_hi = '0; n_hp = 1'b0; n_left = '0;
                n_lx = lx; n_prev = pv; n_phase = ph;
            end
            unique case (ph)
                PH_MAGIC: n_phase = PH_TYPE;
                PH_TYPE: begin
                    n_phase = PH_HEADER;
                    case (i_byte)
                        8'd49: n_fmt = FMT_P1;
                        8'd50: n_fmt = FMT_P2;
                        8'd51: n_fmt = FMT_P3;
                        8'd53: n_fmt = FMT_P5;
                        8'd54: n_fmt = FMT_P6;
                        default: begin
                            n_phase = PH_IDLE;
                            emit = 1'b1;
                            op.is_error = 1'b1;
                        end
                    endcase
                end
                PH_HEADER: begin
                    logic cont;
                    cont = 1'b1;
                    if (lx == LX_COMMENT) begin
                        if (i_byte != 8'd13 && i_byte != 8'd10) cont = 1'b0;
                        else begin
                            lx = pv; pv = LX_COMMENT;
                            n_lx = lx; n_prev = pv;
                        end
                    end
                    if (cont) begin
                        if (lx == LX_WORD) begin
                            if (i_byte == 8'd35) begin
                                n_prev = LX_WORD; n_lx = LX_COMMENT;
                            end else if (is_ws(i_byte)) begin
                                logic [1:0] wc;
                                logic       bad;
                                wc = r_wc + 2'd1;
                                n_wc = wc;
                                n_lx = LX_WSP;
                                if (wc == 2'd1 || wc == 2'd2)
                                    bad = r_bad || r_acc > DimMax;
                                else
                                    bad = r_bad || r_acc == '0 || r_acc > Max16;
                                if (bad) begin
                                    n_phase = PH_IDLE;
                                    emit = 1'b1;
                                    op.is_error = 1'b1;
                                end else begin
                                    if (wc == 2'd1) n_w = r_acc[DIM_BITS-1:0];
                                    else if (wc == 2'd2) n_h = r_acc[DIM_BITS-1:0];
                                    else n_max = r_acc[15:0];
                                    if ((r_fmt == FMT_P1 && wc >= 2'd2) || wc >= 2'd3) begin
                                        n_cnt_pend = 1'b1;
                                    end
                                end
                            end else if (is_dig_c) n_acc = acc_next(r_acc, i_byte);
                            else n_bad = 1'b1;
                        end else begin
                            if (i_byte == 8'd35) begin
                                n_prev = LX_WSP; n_lx = LX_COMMENT;
                            end else if (!is_ws(i_byte)) begin
                                n_acc = is_dig_c ? acc_next('0, i_byte) : '0;
                                n_bad = !is_dig_c;
                                n_prev = LX_WSP; n_lx = LX_WORD;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    if (r_fmt == FMT_P5 || r_fmt == FMT_P6) begin
                        if (r_max < 16'd256) begin
                            do_sample = 1'b1; sval = {8'd0, i_byte};
                        end else if (!r_hp) begin
                            n_hi = i_byte; n_hp = 1'b1;
                        end else begin
                            n_hp = 1'b0; do_sample = 1'b1; sval = {r_hi, i_byte};
                        end
                    end else if (lx == LX_COMMENT) begin
                        if (i_byte == 8'd10) n_lx = LX_WSP;
                    end else if (i_byte == 8'd35 || is_ws(i_byte)) begin
                        if (lx == LX_WORD && r_fmt != FMT_P1) begin
                            do_sample = 1'b1;
                            sval = r_bad ? 16'd0 :
                                (r_acc > Max16 ? 16'hFFFF : r_acc[15:0]);
                            // values beyond 16 bits still clamp to 31
                            if (!r_bad && r_acc > Max16) sval = 16'hFFFF;
                        end
                        n_lx = (i_byte == 8'd35) ? LX_COMMENT : LX_WSP;
                    end else if (r_fmt == FMT_P1) begin
                        n_lx = LX_WORD;
                        px = 1'b1;
                        pv5 = (i_byte == 8'd48) ? 5'd0 : 5'd31;
                    end else begin
                        if (lx != LX_WORD) begin
                            n_lx = LX_WORD;
                            n_acc = is_dig_c ? acc_next('0, i_byte) : '0;
                            n_bad = !is_dig_c;
                        end else if (is_dig_c) n_acc = acc_next(r_acc, i_byte);
                        else n_bad = 1'b1;
                    end
                end
                default: ;
            endcase
            // sample classification
            if (do_sample) begin
                logic gray;
                logic fin;
                gray = (r_fmt == FMT_P2 || r_fmt == FMT_P5);
                fin = gray || r_comp == 2'd2;
                emit = 1'b1;
                op.is_sample = 1'b1;
                op.value = sval;
                op.gray = gray;
                op.comp = gray ? 2'd2 : r_comp;
                op.to_pixel = fin;
                if (!gray) n_comp = (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
            end
            if (px || (do_sample && op.to_pixel)) begin
                logic [31:0] left;
                left = (r_left != '0) ? r_left - 32'd1 : r_left;
                n_left = left;
                op.last = (left == '0);
                if (left == '0) n_phase = PH_IDLE;
                if (px) begin
                    emit = 1'b1;
                    op.is_pixel = 1'b1;
                    op.red = pv5; op.green = pv5; op.blue = pv5;
                end
            end
        end
        op.width = 16'(r_w);
        op.height = 16'(r_h);
        op.maxval = n_max;
        op.format = n_fmt;
        if (op.is_error) begin
            op.width = '0; op.height = '0; op.maxval = '0; op.format = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC; r_lx <= LX_WSP; r_prev <= LX_WORD; r_fmt <= '0;
            r_wc <= '0; r_acc <= '0; r_bad <= 1'b0; r_w <= '0; r_h <= '0;
            r_max <= '0; r_comp <= '0; r_hi <= '0; r_hp <= 1'b0; r_left <= '0;
            r_cnt_pend <= 1'b0;
        end else begin
            r_phase <= n_phase; r_lx <= n_lx; r_prev <= n_prev; r_fmt <= n_fmt;
            r_wc <= n_wc; r_acc <= n_acc; r_bad <= n_bad; r_w <= n_w; r_h <= n_h;
            r_max <= n_max; r_comp <= n_comp; r_hi <= n_hi; r_hp <= n_hp;
            r_left <= n_left; r_cnt_pend <= n_cnt_pend;
        end
        r_prod <= n_w * n_h;
    end

    assign o_op_valid = emit;
    assign o_op = op;
endmodule

FILE: sv/pnm_queue.sv
// short request queue between front and back end
module pnm_queue import pnm_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_op  i_op,
    output logic o_valid,
    input  logic i_ready,
    output t_op  o_op
);
    localparam int AW = $clog2(DEPTH);
    t_op r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    // keep one slot spare for the request that the pixel-count cycle adds
    assign o_ready = r_cnt < (AW+1)'(DEPTH - 1);
    assign o_valid = r_cnt != '0;
    assign o_op = r_mem[r_rp];
    wire wr = i_valid;
    wire rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_op;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

FILE: sv/pnm_back.sv
// back end: scales samples with a serial divider and builds results
module pnm_back import pnm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_op  i_op,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);
    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} t_st;
    t_st r_st;
    t_op r_op;
    logic [20:0] r_rem;   // v*31 fits in 21 bits
    logic [20:0] r_quo;
    logic [4:0]  r_bit;
    logic [4:0]  r_rg_r, r_rg_g;
    t_res r_res;

    assign o_ready = (r_st == ST_IDLE);
    assign o_valid = (r_st == ST_OUT);
    assign o_res = r_res;

    // one restoring division step per cycle
    logic [36:0] trial;
    logic [4:0]  s5;
    always_comb begin
        trial = {16'd0, r_rem} - ({21'd0, r_op.maxval} << r_bit);
        s5 = (r_quo > 21'd31) ? 5'd31 : r_quo[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_rg_r <= '0; r_rg_g <= '0;
        end else begin
            unique case (r_st)
                ST_IDLE: if (i_valid) begin
                    r_op <= i_op;
                    if (i_op.is_sample) begin
                        r_rem <= 21'({5'd0, i_op.value} * 21'd31);
                        r_quo <= '0;
                        r_bit <= 5'd20;
                        r_st <= ST_DIV;
                    end else begin
                        r_res.kind <= i_op.is_error ? KIND_ERROR :
                                      (i_op.is_header ? KIND_HEADER : KIND_PIXEL);
                        r_res.red <= i_op.red;
                        r_res.green <= i_op.green;
                        r_res.blue <= i_op.blue;
                        r_res.last_pixel <= i_op.last;
                        r_res.image_width <= i_op.width;
                        r_res.image_height <= i_op.height;
                        r_res.sample_max <= i_op.maxval;
                        r_res.format <= i_op.format;
                        r_st <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    if (!trial[36]) begin
                        r_rem <= trial[20:0];
                        r_quo <= r_quo | (21'd1 << r_bit);
                    end
                    if (r_bit != 5'd0) begin
                        r_bit <= r_bit - 5'd1;
                    end else begin
                        logic [4:0] q;
                        // last quotient bit folded in, clamped at 31
                        q = !trial[36] ?
                            (((r_quo | 21'd1) > 21'd31) ? 5'd31 : 5'(r_quo | 21'd1)) : s5;
                        if (r_op.gray) begin
                            r_res.red <= q; r_res.green <= q; r_res.blue <= q;
                        end else if (r_op.comp == 2'd0) r_rg_r <= q;
                        else if (r_op.comp == 2'd1) r_rg_g <= q;
                        else begin
                            r_res.red <= r_rg_r; r_res.green <= r_rg_g; r_res.blue <= q;
                        end
                        r_res.kind <= KIND_PIXEL;
                        r_res.last_pixel <= r_op.last;
                        r_res.image_width <= r_op.width;
                        r_res.image_height <= r_op.height;
                        r_res.sample_max <= r_op.maxval;
                        r_res.format <= r_op.format;
                        r_st <= r_op.to_pixel ? ST_OUT : ST_IDLE;
                    end
                end
                ST_OUT: if (i_ready) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: tb/tb_pnm_stream_to_rgb555_top.sv
// testbench for the pnm stream to rgb555 decoder: byte files in, checked results out
`timescale 1ns / 1ps

module tb_pnm_stream_to_rgb555_top;
    import pnm_pkg::*;

    localparam int DimMax = 65535;
    localparam int AccCap = 65536;
    localparam int WatchLimit = 20000;

    typedef enum logic [2:0] {
        PH_MAGIC, PH_TYPE, PH_HEADER, PH_DATA, PH_IDLE
    } t_phase;
    typedef enum logic [1:0] {
        LX_WORD, LX_WSP, LX_COMMENT
    } t_lex;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_byte_req;

    logic i_clk;
    logic i_rst_n;

    pnm_in_if  in_ch ();
    pnm_out_if out_ch ();

    pnm_stream_to_rgb555_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // decoder state of the predictor
    t_phase      dec_phase;
    logic [2:0]  dec_fmt;
    t_lex        dec_lex;
    t_lex        dec_lex_prev;
    logic [1:0]  dec_words;
    int unsigned dec_acc;
    logic        dec_bad;
    int unsigned dec_width;
    int unsigned dec_height;
    int unsigned dec_maxval;
    logic [1:0]  dec_comp;
    logic [4:0]  dec_red;
    logic [4:0]  dec_green;
    logic [7:0]  dec_hi;
    logic        dec_hi_pending;
    int unsigned dec_left;

    t_res        expected_results[$];
    t_byte_req   pending_bytes[$];
    int          n_errors;
    bit          stim_done;
    bit          hold_off;
    bit          calm;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic void decoder_clear();
        dec_phase = PH_MAGIC;
        dec_fmt = FMT_P1;
        dec_lex = LX_WSP;
        dec_lex_prev = LX_WORD;
        dec_words = '0;
        dec_acc = 0;
        dec_bad = 1'b0;
        dec_width = 0;
        dec_height = 0;
        dec_maxval = 0;
        dec_comp = '0;
        dec_red = '0;
        dec_green = '0;
        dec_hi = '0;
        dec_hi_pending = 1'b0;
        dec_left = 0;
    endfunction

    function automatic bit white(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void add_digit(input logic [7:0] c);
        longint unsigned v;
        if (c >= "0" && c <= "9") begin
            v = longint'(dec_acc) * 10 + (c - "0");
            dec_acc = (v > AccCap) ? AccCap : int'(v);
        end else begin
            dec_bad = 1'b1;
        end
    endfunction

    function automatic logic [4:0] to_five_bits(input int unsigned v);
        longint unsigned q;
        if (dec_maxval == 0) return '0;
        q = (longint'(v) * 31) / dec_maxval;
        return (q > 31) ? 5'd31 : 5'(q);
    endfunction

    function automatic void push_result(input logic [1:0] kind, input logic [4:0] r,
                                        input logic [4:0] g, input logic [4:0] b,
                                        input logic last);
        t_res res;
        bit info;
        info = kind != KIND_ERROR;
        res.kind = kind;
        res.red = r;
        res.green = g;
        res.blue = b;
        res.last_pixel = last;
        res.image_width = info ? dec_width[15:0] : '0;
        res.image_height = info ? dec_height[15:0] : '0;
        res.sample_max = info ? dec_maxval[15:0] : '0;
        res.format = info ? dec_fmt : '0;
        expected_results.push_back(res);
    endfunction

    function automatic void decoder_fail();
        dec_phase = PH_IDLE;
        push_result(KIND_ERROR, 0, 0, 0, 0);
    endfunction

    function automatic void emit_pixel(input logic [4:0] r, input logic [4:0] g,
                                       input logic [4:0] b);
        logic last;
        last = 1'b0;
        if (dec_left > 0) dec_left--;
        if (dec_left == 0) begin
            last = 1'b1;
            dec_phase = PH_IDLE;
        end
        push_result(KIND_PIXEL, r, g, b, last);
    endfunction

    function automatic void close_header_word();
        int unsigned need;
        int unsigned v;
        longint unsigned n;
        need = (dec_fmt == FMT_P1) ? 2 : 3;
        v = dec_acc;
        dec_words = dec_words + 2'd1;
        if (dec_words == 2'd1) begin
            if (dec_bad || v > DimMax) begin decoder_fail(); return; end
            dec_width = v;
        end else if (dec_words == 2'd2) begin
            if (dec_bad || v > DimMax) begin decoder_fail(); return; end
            dec_height = v;
        end else begin
            if (dec_bad || v == 0 || v > 65535) begin decoder_fail(); return; end
            dec_maxval = v;
        end
        dec_lex = LX_WSP;
        if (dec_words >= need) begin
            n = longint'(dec_width) * dec_height;
            dec_left = (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : int'(n);
            dec_phase = (dec_left != 0) ? PH_DATA : PH_IDLE;
            push_result(KIND_HEADER, 0, 0, 0, 0);
        end
    endfunction

    function automatic void header_char(input logic [7:0] c);
        if (dec_lex == LX_COMMENT) begin
            if (c != 8'd13 && c != 8'd10) return;
            dec_lex = dec_lex_prev;
            dec_lex_prev = LX_COMMENT;
        end
        if (dec_lex == LX_WORD) begin
            if (c == "#") begin
                dec_lex_prev = LX_WORD;
                dec_lex = LX_COMMENT;
            end else if (white(c)) begin
                close_header_word();
            end else begin
                add_digit(c);
            end
        end else begin
            if (c == "#") begin
                dec_lex_prev = LX_WSP;
                dec_lex = LX_COMMENT;
            end else if (!white(c)) begin
                dec_acc = 0;
                dec_bad = 1'b0;
                add_digit(c);
                dec_lex_prev = LX_WSP;
                dec_lex = LX_WORD;
            end
        end
    endfunction

    function automatic void take_sample(input int unsigned v);
        logic [4:0] s;
        s = to_five_bits(v);
        if (dec_fmt == FMT_P2 || dec_fmt == FMT_P5) begin
            emit_pixel(s, s, s);
        end else if (dec_comp == 2'd0) begin
            dec_red = s;
            dec_comp = 2'd1;
        end else if (dec_comp == 2'd1) begin
            dec_green = s;
            dec_comp = 2'd2;
        end else begin
            dec_comp = 2'd0;
            emit_pixel(dec_red, dec_green, s);
        end
    endfunction

    function automatic void ascii_char(input logic [7:0] c);
        logic [4:0] v;
        if (dec_lex == LX_COMMENT) begin
            if (c == 8'd10) dec_lex = LX_WSP;
            return;
        end
        if (c == "#" || white(c)) begin
            if (dec_lex == LX_WORD && dec_fmt != FMT_P1)
                take_sample(dec_bad ? 0 : dec_acc);
            dec_lex = (c == "#") ? LX_COMMENT : LX_WSP;
            return;
        end
        if (dec_fmt == FMT_P1) begin
            v = (c == "0") ? 5'd0 : 5'd31;
            dec_lex = LX_WORD;
            emit_pixel(v, v, v);
            return;
        end
        if (dec_lex != LX_WORD) begin
            dec_acc = 0;
            dec_bad = 1'b0;
            dec_lex = LX_WORD;
        end
        add_digit(c);
    endfunction

    // predicted results of one accepted byte
    function automatic void decode_byte(input logic [7:0] c, input logic first);
        if (first) decoder_clear();
        case (dec_phase)
            PH_MAGIC: dec_phase = PH_TYPE;
            PH_TYPE: begin
                case (c)
                    "1": dec_fmt = FMT_P1;
                    "2": dec_fmt = FMT_P2;
                    "3": dec_fmt = FMT_P3;
                    "5": dec_fmt = FMT_P5;
                    "6": dec_fmt = FMT_P6;
                    default: begin decoder_fail(); return; end
                endcase
                dec_phase = PH_HEADER;
            end
            PH_HEADER: header_char(c);
            PH_DATA: begin
                if (dec_fmt == FMT_P5 || dec_fmt == FMT_P6) begin
                    if (dec_maxval < 256) take_sample(c);
                    else if (!dec_hi_pending) begin
                        dec_hi = c;
                        dec_hi_pending = 1'b1;
                    end else begin
                        dec_hi_pending = 1'b0;
                        take_sample(int'(dec_hi) * 256 + c);
                    end
                end else begin
                    ascii_char(c);
                end
            end
            default: ;
        endcase
    endfunction

    // stimulus building
    function automatic void put_byte(input logic [7:0] c, input logic first = 1'b0);
        t_byte_req r;
        r.data = c;
        r.first = first;
        pending_bytes.push_back(r);
    endfunction

    function automatic void put_text(input string s, input bit fresh = 1'b1);
        for (int i = 0; i < s.len(); i++) put_byte(s[i], fresh && i == 0);
    endfunction

    function automatic string random_sep();
        case ($urandom_range(0, 5))
            0: return "\t";
            1: return "\n";
            2: return "\r\n";
            3: return " #c\n";
            4: return "  ";
            default: return " ";
        endcase
    endfunction

    function automatic void random_file();
        int fmt_pick;
        int w;
        int h;
        int mx;
        int n_samples;
        string hdr;
        fmt_pick = $urandom_range(0, 4);
        w = $urandom_range(0, 4);
        h = $urandom_range(1, 3);
        mx = ($urandom_range(0, 2) == 0) ? $urandom_range(256, 65535) : $urandom_range(1, 255);
        if ($urandom_range(0, 9) == 0) mx = 65535;
        hdr = $sformatf("P%s%s%0d%s%0d", fmt_pick == 0 ? "1" : fmt_pick == 1 ? "2" :
                        fmt_pick == 2 ? "3" : fmt_pick == 3 ? "5" : "6",
                        random_sep(), w, random_sep(), h);
        if (fmt_pick != 0) hdr = {hdr, random_sep(), $sformatf("%0d", mx)};
        hdr = {hdr, (fmt_pick >= 3) ? "\n" : random_sep()};
        put_text(hdr);
        n_samples = w * h * ((fmt_pick == 2 || fmt_pick == 4) ? 3 : 1);
        if ($urandom_range(0, 7) == 0) n_samples = n_samples / 2;
        for (int i = 0; i < n_samples; i++) begin
            int v;
            v = ($urandom_range(0, 3) == 0) ? mx : $urandom_range(0, mx);
            case (fmt_pick)
                0: put_byte($urandom_range(0, 1) ? "0" : 8'(8'd33 + $urandom_range(0, 200)));
                1, 2: begin
                    if ($urandom_range(0, 15) == 0) put_text("1x", 1'b0);
                    else put_text($sformatf("%0d", v), 1'b0);
                    put_text(random_sep(), 1'b0);
                end
                default: begin
                    if (mx >= 256) put_byte(8'(v >> 8));
                    put_byte(8'(v));
                end
            endcase
        end
        // noise after the image
        if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < 3; i++) put_byte(8'($urandom));
    endfunction

    function automatic void random_noise_file();
        int n;
        n = $urandom_range(2, 12);
        put_byte(8'($urandom), 1'b1);
        put_byte($urandom_range(0, 1) ? 8'($urandom) : "3");
        for (int i = 0; i < n; i++)
            put_byte($urandom_range(0, 2) ? 8'($urandom_range(32, 57)) : 8'($urandom));
    endfunction

    initial begin
        decoder_clear();
        n_errors = 0;
        stim_done = 1'b0;
        // directed files: every type, bad type, bad words, limits, comments
        put_text("P1 2 2\n0 1 x0");
        put_text("P2 1#c\n 2 65535\n0 65535 ");
        put_text("P3 1 1 255 255 0 128 ");
        put_text("P5\n2 1\n255\n");
        put_byte(8'h00); put_byte(8'hFF);
        put_text("P6 1 1 65535\n");
        put_byte(8'hFF); put_byte(8'hFF); put_byte(8'h00); put_byte(8'h00);
        put_byte(8'h80); put_byte(8'h01);
        put_text("P4");
        put_text("P2 1 1 0 ");
        put_text("P2 1 1 65536 ");
        put_text("P2 65536 1 ");
        put_text("P2 1a 1 ");
        put_text("P5 0 7 9 abc");
        put_text("P2 2 1 5 9z 3\n");
        put_text("P3 99999999999 0 1 ");
        put_text("P1 1 1#x\r1");
        repeat (400) begin
            if ($urandom_range(0, 9) == 0) random_noise_file();
            else random_file();
            if (pending_bytes.size() > 880) break;
        end
        put_byte(8'hFF, 1'b1);
        put_byte(8'h00);
    end

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.in_byte <= '0;
            in_ch.start_file <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 31)) begin
                t_byte_req r;
                r = pending_bytes.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.in_byte <= r.data;
                in_ch.start_file <= r.first;
            end else begin
                in_ch.valid <= 1'b0;
                if (pending_bytes.size() == 0) stim_done <= 1'b1;
            end
        end
    end

    // accepted bytes feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            decode_byte(in_ch.in_byte, in_ch.start_file);
    end

    // receiver ready with a long hold-off once and a calm stretch
    int cyc;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            cyc <= 0;
            hold_off <= 1'b0;
            calm <= 1'b0;
        end else begin
            cyc <= cyc + 1;
            hold_off <= cyc >= 500 && cyc < 900;
            calm <= cyc >= 1500 && cyc < 4000;
            out_ch.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 31);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result kind", out_ch.kind, -1);
            end else begin
                t_res w;
                w = expected_results.pop_front();
                if (out_ch.kind != w.kind) report_mismatch("kind", out_ch.kind, w.kind);
                if (out_ch.red != w.red) report_mismatch("red", out_ch.red, w.red);
                if (out_ch.green != w.green) report_mismatch("green", out_ch.green, w.green);
                if (out_ch.blue != w.blue) report_mismatch("blue", out_ch.blue, w.blue);
                if (out_ch.last_pixel != w.last_pixel)
                    report_mismatch("last_pixel", out_ch.last_pixel, w.last_pixel);
                if (out_ch.image_width != w.image_width)
                    report_mismatch("image_width", out_ch.image_width, w.image_width);
                if (out_ch.image_height != w.image_height)
                    report_mismatch("image_height", out_ch.image_height, w.image_height);
                if (out_ch.sample_max != w.sample_max)
                    report_mismatch("sample_max", out_ch.sample_max, w.sample_max);
                if (out_ch.format != w.format)
                    report_mismatch("format", out_ch.format, w.format);
            end
        end
    end

    // reset, end of run and watchdog
    initial begin
        int idle;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle = 0;
        while (!(stim_done && expected_results.size() == 0) && idle < WatchLimit) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
            else idle++;
        end
        if (idle >= WatchLimit) begin
            $display("tb_pnm_stream_to_rgb555_top: done, errors");
            $finish;
        end else begin
            repeat (100) @(posedge i_clk);
            if (n_errors == 0 && expected_results.size() == 0)
                $display("tb_pnm_stream_to_rgb555_top: done, clean");
            else
                $display("tb_pnm_stream_to_rgb555_top: done, errors");
            $finish;
        end
    end

endmodule

FILE: files.f
sv/pnm_pkg.sv
sv/pnm_if.sv
sv/pnm_front.sv
sv/pnm_queue.sv
sv/pnm_back.sv
sv/pnm_stream_to_rgb555_top.sv
tb/tb_pnm_stream_to_rgb555_top.sv
